// ----- rtl/cross_product_unit_normal_assert.svh -----
// Assertion macros used by the top-level RTL module
`ifndef CROSS_PRODUCT_UNIT_NORMAL_ASSERT_SVH
`define CROSS_PRODUCT_UNIT_NORMAL_ASSERT_SVH

`define CPN_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cpn assertion failed");

`define CPN_ASSERT_LATENCY(lbl, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("cpn latency check failed");

`endif

// ----- rtl/cpn_pkg.sv -----
package cpn_pkg;

  localparam int unsigned NUM_LANES = 3;

  typedef struct packed {
    logic valid;
    logic deg;
  } cpn_ctl_t;

endpackage

// ----- rtl/cpn_cross.sv -----
module cpn_cross #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  logic signed [IN_WIDTH-1:0]                        a_x,
  input  logic signed [IN_WIDTH-1:0]                        a_y,
  input  logic signed [IN_WIDTH-1:0]                        a_z,
  input  logic signed [IN_WIDTH-1:0]                        b_x,
  input  logic signed [IN_WIDTH-1:0]                        b_y,
  input  logic signed [IN_WIDTH-1:0]                        b_z,
  output cpn_pkg::cpn_ctl_t                                 ctl,
  output logic [cpn_pkg::NUM_LANES-1:0]                     neg,
  output logic [4*IN_WIDTH+1:0]                             len2,
  output logic [cpn_pkg::NUM_LANES-1:0][4*IN_WIDTH+2*OUT_FRAC_BITS-1:0] tgt
);
  import cpn_pkg::*;

  localparam int PW = 2 * IN_WIDTH;
  localparam int CW = 2 * IN_WIDTH;
  localparam int SW = 4 * IN_WIDTH;
  localparam int LW = 4 * IN_WIDTH + 2;
  localparam int RW = 4 * IN_WIDTH + 2 * OUT_FRAC_BITS;

  logic                              v1, v2, v3;
  logic signed [NUM_LANES-1:0][1:0][PW-1:0] prod;
  logic [NUM_LANES-1:0]              neg2, neg3;
  logic [NUM_LANES-1:0][CW-1:0]      cmag;
  logic [NUM_LANES-1:0][SW-1:0]      sq;
  logic signed [PW:0]                cdiff [NUM_LANES];
  logic [NUM_LANES-1:0][CW-1:0]      cmag_next;
  logic [LW-1:0]                     len2_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ctl <= '0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      ctl.valid <= v3;
      ctl.deg <= (len2_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    prod[0][0] <= a_y * b_z;
    prod[0][1] <= a_z * b_y;
    prod[1][0] <= a_z * b_x;
    prod[1][1] <= a_x * b_z;
    prod[2][0] <= a_x * b_y;
    prod[2][1] <= a_y * b_x;
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      cdiff[i] = (PW+1)'(signed'(prod[i][0])) - (PW+1)'(signed'(prod[i][1]));
      cmag_next[i] = CW'(cdiff[i][PW] ? -cdiff[i] : cdiff[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      neg2[i] <= cdiff[i][PW];
      cmag[i] <= cmag_next[i];
      sq[i]   <= cmag[i] * cmag[i];
      neg3[i] <= neg2[i];
    end
  end

  assign len2_next = LW'(sq[0]) + LW'(sq[1]) + LW'(sq[2]);

  always_ff @(posedge clk) begin
    len2 <= len2_next;
    neg  <= neg3;
    for (int i = 0; i < NUM_LANES; i++) begin
      tgt[i] <= RW'(sq[i]) << (2 * OUT_FRAC_BITS);
    end
  end

endmodule

// ----- rtl/cpn_root_step.sv -----
module cpn_root_step #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 15,
  parameter int BIT           = 15
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  cpn_pkg::cpn_ctl_t                                 ctl_in,
  input  logic [cpn_pkg::NUM_LANES-1:0]                     neg_in,
  input  logic [4*IN_WIDTH+1:0]                             len2_in,
  input  logic [cpn_pkg::NUM_LANES-1:0][4*IN_WIDTH+2*OUT_FRAC_BITS+3:0] r_in,
  input  logic [cpn_pkg::NUM_LANES-1:0][4*IN_WIDTH+2*OUT_FRAC_BITS+3:0] p_in,
  input  logic [cpn_pkg::NUM_LANES-1:0][OUT_FRAC_BITS:0]    q_in,
  output cpn_pkg::cpn_ctl_t                                 ctl_out,
  output logic [cpn_pkg::NUM_LANES-1:0]                     neg_out,
  output logic [4*IN_WIDTH+1:0]                             len2_out,
  output logic [cpn_pkg::NUM_LANES-1:0][4*IN_WIDTH+2*OUT_FRAC_BITS+3:0] r_out,
  output logic [cpn_pkg::NUM_LANES-1:0][4*IN_WIDTH+2*OUT_FRAC_BITS+3:0] p_out,
  output logic [cpn_pkg::NUM_LANES-1:0][OUT_FRAC_BITS:0]    q_out
);
  import cpn_pkg::*;

  localparam int WW = 4 * IN_WIDTH + 2 * OUT_FRAC_BITS + 4;

  logic [WW-1:0]        lw;
  logic [WW-1:0]        d [NUM_LANES];
  logic [NUM_LANES-1:0] take;

  assign lw = WW'(len2_in);

  // trial bit: (q + 2^b)^2 L - q^2 L = 2^(b+1) qL + 2^(2b) L
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      d[i] = (p_in[i] << (BIT + 1)) + (lw << (2 * BIT));
      take[i] = (d[i] <= r_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    neg_out  <= neg_in;
    len2_out <= len2_in;
    for (int i = 0; i < NUM_LANES; i++) begin
      r_out[i] <= take[i] ? r_in[i] - d[i] : r_in[i];
      p_out[i] <= take[i] ? p_in[i] + (lw << BIT) : p_in[i];
      q_out[i] <= q_in[i] | ((OUT_FRAC_BITS+1)'(take[i]) << BIT);
    end
  end

endmodule

// ----- rtl/cross_product_unit_normal.sv -----
// Unit normal of two 3D vectors: n = (a x b) / |a x b|.
// Input word: a_x..b_z, signed Q8.8 at the default width, taken at a rising
// edge where start is high and busy is low. busy is high only during reset.
// Result word: n_x, n_y, n_z signed Q1.15 (+32768 is exactly one), each
// component the true quotient truncated toward zero, with degenerate set and
// all components zero when the cross product is the zero vector.
// done is high for exactly one cycle per result; the receiver cannot stall.
// Pipeline: from the accepting edge a word passes the registers for
// products, cross terms, squares and length sum, a registered step per
// quotient bit in the restoring square-root-and-divide chain, and one
// output register, which also drives done.
// Throughput: one word per cycle while busy is low; every stage carries its own valid bit.
// Reset (rst, synchronous) drops every word in flight; no result follows.
module cross_product_unit_normal #(
  parameter int IN_WIDTH      = 16,
  parameter int OUT_FRAC_BITS = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [IN_WIDTH-1:0]   a_x,
  input  logic signed [IN_WIDTH-1:0]   a_y,
  input  logic signed [IN_WIDTH-1:0]   a_z,
  input  logic signed [IN_WIDTH-1:0]   b_x,
  input  logic signed [IN_WIDTH-1:0]   b_y,
  input  logic signed [IN_WIDTH-1:0]   b_z,
  output logic                         done,
  output logic signed [OUT_FRAC_BITS+1:0] n_x,
  output logic signed [OUT_FRAC_BITS+1:0] n_y,
  output logic signed [OUT_FRAC_BITS+1:0] n_z,
  output logic                         degenerate
);
  import cpn_pkg::*;
  `include "cross_product_unit_normal_assert.svh"

  localparam int LW    = 4 * IN_WIDTH + 2;
  localparam int RW    = 4 * IN_WIDTH + 2 * OUT_FRAC_BITS;
  localparam int WW    = RW + 4;
  localparam int QW    = OUT_FRAC_BITS + 1;
  localparam int OW    = OUT_FRAC_BITS + 2;
  localparam int NST   = OUT_FRAC_BITS + 1;
  localparam int LAT   = OUT_FRAC_BITS + 6;
  localparam logic signed [OW-1:0] ONE = OW'(1) << OUT_FRAC_BITS;

  cpn_ctl_t                        ctl  [NST+1];
  logic [NUM_LANES-1:0]            neg  [NST+1];
  logic [LW-1:0]                   len2 [NST+1];
  logic [NUM_LANES-1:0][WW-1:0]    r    [NST+1];
  logic [NUM_LANES-1:0][WW-1:0]    p    [NST+1];
  logic [NUM_LANES-1:0][QW-1:0]    q    [NST+1];
  logic [NUM_LANES-1:0][RW-1:0]    tgt;
  logic [NUM_LANES-1:0][WW-1:0]    r_seed;
  logic signed [OW-1:0]            res_next [NUM_LANES];

  assign busy = rst;

  cpn_cross #(
    .IN_WIDTH      (IN_WIDTH),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_cross (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z),
    .ctl      (ctl[0]),
    .neg      (neg[0]),
    .len2     (len2[0]),
    .tgt      (tgt)
  );

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      r_seed[i] = WW'(tgt[i]);
    end
  end

  assign r[0] = r_seed;
  assign p[0] = '0;
  assign q[0] = '0;

  for (genvar s = 0; s < NST; s++) begin : g_root
    cpn_root_step #(
      .IN_WIDTH      (IN_WIDTH),
      .OUT_FRAC_BITS (OUT_FRAC_BITS),
      .BIT           (OUT_FRAC_BITS - s)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .ctl_in   (ctl[s]),
      .neg_in   (neg[s]),
      .len2_in  (len2[s]),
      .r_in     (r[s]),
      .p_in     (p[s]),
      .q_in     (q[s]),
      .ctl_out  (ctl[s+1]),
      .neg_out  (neg[s+1]),
      .len2_out (len2[s+1]),
      .r_out    (r[s+1]),
      .p_out    (p[s+1]),
      .q_out    (q[s+1])
    );
  end

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      if (ctl[NST].deg) begin
        res_next[i] = '0;
      end else if (neg[NST][i]) begin
        res_next[i] = -signed'(OW'(q[NST][i]));
      end else begin
        res_next[i] = signed'(OW'(q[NST][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[NST].valid;
    end
  end

  always_ff @(posedge clk) begin
    n_x        <= res_next[0];
    n_y        <= res_next[1];
    n_z        <= res_next[2];
    degenerate <= ctl[NST].deg;
  end

  `CPN_ASSERT_LATENCY(a_latency, start && !busy, LAT, done)
  `CPN_ASSERT_IMPL(a_deg_zero, done && degenerate, n_x == '0 && n_y == '0 && n_z == '0)
  `CPN_ASSERT_IMPL(a_unit_x, done, n_x <= ONE && n_x >= -ONE)
  `CPN_ASSERT_IMPL(a_unit_yz, done, n_y <= ONE && n_y >= -ONE && n_z <= ONE && n_z >= -ONE)

endmodule

// ----- sim/tb_cross_product_unit_normal.sv -----
`timescale 1ns / 100ps

module tb_cross_product_unit_normal;

  localparam int IN_W    = 16;
  localparam int FRAC    = 15;
  localparam int OUT_W   = FRAC + 2;
  localparam int LATENCY = FRAC + 6;
  localparam int LIMIT   = 200000;

  typedef struct {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    deg;
  } normal_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [IN_W-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic done;
  logic signed [OUT_W-1:0] n_x, n_y, n_z;
  logic degenerate;

  normal_t normals_due[$];
  int      idle_pct;
  int      mismatches;
  int      words_sent;
  int      words_checked;
  int      degenerate_seen;
  longint  cycles;

  cross_product_unit_normal uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .done(done), .n_x(n_x), .n_y(n_y), .n_z(n_z), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [OUT_W-1:0] unit_component(input longint c, input logic [127:0] len2);
    logic [127:0] cm;
    logic [127:0] tgt;
    logic [127:0] q;
    logic [127:0] cand;
    logic [127:0] signed_q;
    cm = (c < 0) ? 128'(-c) : 128'(c);
    tgt = (cm * cm) << (2 * FRAC);
    q = '0;
    for (int b = FRAC; b >= 0; b--) begin
      cand = q | (128'd1 << b);
      if (cand * cand * len2 <= tgt) q = cand;
    end
    signed_q = (c < 0) ? -q : q;
    return signed_q[OUT_W-1:0];
  endfunction

  function automatic normal_t predict_normal(input logic signed [IN_W-1:0] ax, ay, az, bx, by, bz);
    normal_t r;
    longint cx, cy, cz;
    logic [127:0] len2;
    cx = longint'(ay) * bz - longint'(az) * by;
    cy = longint'(az) * bx - longint'(ax) * bz;
    cz = longint'(ax) * by - longint'(ay) * bx;
    len2 = 128'(cx * cx) + 128'(cy * cy) + 128'(cz * cz);
    if (len2 == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.deg = 1'b1;
    end else begin
      r.nx = unit_component(cx, len2);
      r.ny = unit_component(cy, len2);
      r.nz = unit_component(cz, len2);
      r.deg = 1'b0;
    end
    return r;
  endfunction

  task automatic send_word(input logic signed [IN_W-1:0] ax, ay, az, bx, by, bz);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    a_x <= ax; a_y <= ay; a_z <= az;
    b_x <= bx; b_y <= by; b_z <= bz;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    normals_due.push_back(predict_normal(ax, ay, az, bx, by, bz));
    words_sent++;
  endtask

  task automatic test_directed;
    send_word(0, 0, 0, 0, 0, 0);
    send_word(256, 0, 0, 0, 256, 0);
    send_word(0, 256, 0, 256, 0, 0);
    send_word(0, 0, 256, 256, 0, 0);
    send_word(0, 256, 0, 0, 0, 256);
    send_word(-32768, 0, 0, 0, -32768, 0);
    send_word(32767, 0, 0, 0, -32768, 0);
    send_word(32767, 32767, 32767, -32768, -32768, -32768);
    send_word(32767, 32767, 32767, 32767, 32767, 32767);
    send_word(-32768, -32768, -32768, 32767, -32768, 32767);
    send_word(32767, -32768, 0, -32768, 32767, 32767);
    send_word(-32768, 32767, -32768, 32767, -32768, -32768);
    send_word(1, 0, 0, 0, 1, 0);
    send_word(1, 1, 0, -1, 1, 0);
    send_word(-1, -1, -1, 1, 2, 3);
    send_word(100, 200, 300, 200, 400, 600);
    send_word(-32768, -32768, -32768, -32768, -32768, -32768);
    send_word(32767, 1, 0, 32767, 2, 0);
    send_word(3, 4, 0, 0, 0, 5);
    send_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
  endtask

  task automatic test_random(input int count, input int sender_idle);
    logic signed [IN_W-1:0] v[6];
    int k;
    int shape;
    idle_pct = sender_idle;
    repeat (count) begin
      shape = int'($urandom_range(9));
      foreach (v[i]) v[i] = IN_W'($urandom);
      case (shape)
        0: begin
          k = int'($urandom_range(7)) - 4;
          foreach (v[i]) if (i < 3) v[i] = IN_W'(int'($urandom_range(4000)) - 2000);
          v[3] = IN_W'(v[0] * k); v[4] = IN_W'(v[1] * k); v[5] = IN_W'(v[2] * k);
        end
        1: begin
          foreach (v[i]) v[i] = IN_W'(int'($urandom_range(8)) - 4);
        end
        2: begin
          v[1] = 0; v[2] = 0; v[3] = 0; v[5] = 0;
        end
        default: ;
      endcase
      send_word(v[0], v[1], v[2], v[3], v[4], v[5]);
    end
    idle_pct = 0;
  endtask

  always @(posedge clk) begin
    normal_t want;
    if (!rst && done) begin
      if (normals_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result n=(%0d,%0d,%0d) deg=%0b",
                                       n_x, n_y, n_z, degenerate);
      end else begin
        want = normals_due.pop_front();
        words_checked++;
        if (degenerate) degenerate_seen++;
        if (n_x !== want.nx || n_y !== want.ny || n_z !== want.nz ||
            degenerate !== want.deg) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected (%0d,%0d,%0d) deg=%0b, got (%0d,%0d,%0d) deg=%0b",
                     want.nx, want.ny, want.nz, want.deg, n_x, n_y, n_z, degenerate);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    cycles = 0;
    mismatches = 0;
    words_sent = 0;
    words_checked = 0;
    degenerate_seen = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    a_x = '0; a_y = '0; a_z = '0;
    b_x = '0; b_y = '0; b_z = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed;
    test_random(210, 30);
    test_random(210, 50);
    test_random(210, 0);
    start <= 1'b0;
    while (normals_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (normals_due.size() != 0) mismatches++;
    $display("sent %0d words, checked %0d results, %0d degenerate", words_sent,
             words_checked, degenerate_seen);
    $display("covered axis, parallel, zero and full-range vectors at three idle rates");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
